// File: rtl/preintegration_table_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pre-integrated transfer function table
// Concurrent property wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PREINTEGRATION_TABLE_ENGINE_MACROS_SVH
`define PREINTEGRATION_TABLE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("property failed");
// Consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("property failed");
`else
`define PTE_ASSERT_IMP(label, clk, rst, ante, cons)
`define PTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Types, widths, constants and the opacity threshold table of the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pte_pkg;

   localparam int IDX_W    = 8;
   localparam int CH_W     = 8;
   localparam int EIU_W    = 9;
   localparam int NUM_CH   = 3;
   localparam int CH_ALPHA = 3;
   localparam int INT_W    = 26;
   localparam int OPA_W    = 17;
   localparam int SUM_W    = 9;
   localparam int PROD_W   = 18;
   localparam int FRAC_W   = 8;

   // Color divide: numerator, divisor and quotient bits before saturation.
   localparam int CNUM_W   = 27;
   localparam int CDEN_W   = 18;
   localparam int COLOR_QB = 8;
   // Opacity exponent divide, x in 4.8.
   localparam int XNUM_W   = 26;
   localparam int XDEN_W   = 17;
   localparam int X_QB     = 11;
   localparam int XQ_W     = 12;

   localparam int COLOR_FULL      = 255;
   localparam int ROUND_HALF      = 127;
   localparam int COLOR_BIAS_STEP = 510;
   localparam int COLOR_DEN_STEP  = 1020;
   localparam int X_BIAS_STEP     = 255;
   localparam int X_DEN_STEP      = 510;
   localparam int X_SAT           = 2048;
   localparam int ALPHA_LEVELS    = 256;
   localparam int THR_W           = 12;

   localparam logic [EIU_W-1:0] EIU_RESET = EIU_W'(256);
   localparam logic [CH_W-1:0]  ALPHA_MSB = 8'h80;

   localparam logic [63:0] EXP_ONE     = 64'h0000_0001_0000_0000;
   localparam logic [63:0] EXP_HALF    = 64'h0000_0000_8000_0000;
   localparam logic [63:0] EXP_STEP_K  = 64'd4278222805;
   localparam logic [THR_W-1:0] THR_NONE = '1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef logic [3:0][CH_W-1:0] rgba_type;

   typedef struct packed {
      rgba_type                       color;
      logic [NUM_CH-1:0][INT_W-1:0]   color_int;
      logic [OPA_W-1:0]               opacity_int;
   } table_word_type;

   typedef logic [ALPHA_LEVELS-1:0][THR_W-1:0] thr_table_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_MUL,
      ST_LD_WR,
      ST_Q_RDH,
      ST_Q_RDL,
      ST_Q_PREP,
      ST_Q_NUM,
      ST_Q_LAUNCH,
      ST_Q_DIV,
      ST_Q_ALPHA
   } state_type;

   // For each opacity level, the smallest x whose 1-exp(-x) rounds to at least
   // that level. Opacity never falls as x grows, so a search over levels
   // gives the same answer as walking the exponent chain.
   function automatic thr_table_type build_alpha_thr();
      thr_table_type t;
      logic [63:0]   e;
      logic [63:0]   lvl;
      int            nv;
      for (int j = 0; j < ALPHA_LEVELS; j++) begin
         t[j] = THR_NONE;
      end
      e  = EXP_ONE;
      nv = 0;
      for (int x = 0; x <= X_SAT; x++) begin
         lvl = (64'(COLOR_FULL) * (EXP_ONE - e) + EXP_HALF) >> 32;
         while ((nv < ALPHA_LEVELS) && (64'(nv) <= lvl)) begin
            t[nv] = THR_W'(x);
            nv    = nv + 1;
         end
         e = (e * EXP_STEP_K + EXP_HALF) >> 32;
      end
      return t;
   endfunction

   localparam thr_table_type ALPHA_THR = build_alpha_thr();

endpackage

// File: rtl/pte_serial_div.sv
// ----------------------------------------------------------------------------
// pte_serial_div
// Restoring divider, one quotient bit per cycle, for numerators below
// the divisor times two to the number of quotient bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_serial_div #(
   parameter int DEN_W = 18,
   parameter int QB    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DEN_W+QB-1:0]   num,
   input  logic [DEN_W-1:0]      den,
   output logic                  busy,
   output logic [QB-1:0]         quot
);
   import pte_pkg::*;

   localparam int W  = DEN_W + QB;
   localparam int CW = $clog2(QB + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsh_ff;
   logic [QB-1:0] quot_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          fits;

   always_comb begin
      fits   = rem_ff >= dsh_ff;
      rem_in = fits ? (rem_ff - dsh_ff) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(QB);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // The divisor starts aligned to the top quotient bit and walks down.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsh_ff <= W'(den) << (QB - 1);
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[QB-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// File: rtl/preintegration_table_engine.sv
// ----------------------------------------------------------------------------
// preintegration_table_engine: pre-integrated transfer function table
// Load beat: busy while it reads the previous entry, multiplies and writes; no result.
// Query beat: reads both entries, runs the 11-step serial x divider beside the color
//   dividers, then the 8-step opacity search up to the result strobe; a bad index
//   answers next cycle. A new request is taken only once the last one is finished.
// Reset is synchronous: control cleared, entries_in_use set to 256, table undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preintegration_table_engine_macros.svh"

module preintegration_table_engine #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic [pte_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [pte_pkg::CH_W-1:0]    req_entry_red,
   input  logic [pte_pkg::CH_W-1:0]    req_entry_green,
   input  logic [pte_pkg::CH_W-1:0]    req_entry_blue,
   input  logic [pte_pkg::CH_W-1:0]    req_entry_alpha,
   input  logic [pte_pkg::IDX_W-1:0]   req_front_index,
   input  logic [pte_pkg::IDX_W-1:0]   req_back_index,
   output logic                        rsp_valid,
   output logic [pte_pkg::CH_W-1:0]    rsp_out_red,
   output logic [pte_pkg::CH_W-1:0]    rsp_out_green,
   output logic [pte_pkg::CH_W-1:0]    rsp_out_blue,
   output logic [pte_pkg::CH_W-1:0]    rsp_out_alpha,
   output logic                        rsp_index_error,
   input  logic                        csr_we,
   input  logic [pte_pkg::EIU_W-1:0]   csr_wdata
);
   import pte_pkg::*;

   localparam int AW    = $clog2(MAX_ENTRIES);
   localparam int CDV_W = CDEN_W + COLOR_QB;
   localparam int XDV_W = XDEN_W + X_QB;

   state_type state_ff, state_in;

   logic [EIU_W-1:0] eiu_ff;

   logic [AW-1:0]    idx_ff, lo_addr_ff, hi_addr_ff, rd_addr;
   logic             zero_idx_ff;
   rgba_type         color_ff;
   logic [IDX_W-1:0] n_ff, lo_idx, hi_idx;
   logic             eq_ff;

   table_word_type   table_mem [MAX_ENTRIES];
   table_word_type   rd_ff, hold_ff, wr_data;
   logic             rd_en, wr_en, div_start;

   logic [SUM_W-1:0]                  ta, ta_ff;
   logic [NUM_CH-1:0][SUM_W-1:0]      mop_a, mop_b;
   logic [NUM_CH-1:0][PROD_W-1:0]     prod, prod_ff;

   logic [NUM_CH-1:0][INT_W-1:0]      dc_ff;
   logic [OPA_W-1:0]                  da_ff;
   logic [NUM_CH-1:0][CNUM_W-1:0]     cnum_ff;
   logic [CDEN_W-1:0]                 cden_ff;
   logic [XNUM_W-1:0]                 xnum_ff;
   logic [XDEN_W-1:0]                 xden_ff;
   logic [NUM_CH-1:0]                 csat, csat_ff;
   logic                              xsat, xsat_ff;
   logic [NUM_CH-1:0][CDV_W-1:0]      cdiv_num;
   logic [XDV_W-1:0]                  xdiv_num;
   logic [NUM_CH-1:0][COLOR_QB-1:0]   cquot;
   logic [X_QB-1:0]                   xquot;
   logic [NUM_CH:0]                   div_busy;

   logic [XQ_W-1:0] x_ff;
   logic [CH_W-1:0] acc_ff, abit_ff, trial, acc_in;

   logic                         rsp_valid_ff, rsp_err_ff;
   logic [NUM_CH-1:0][CH_W-1:0]  rsp_color_ff;
   logic [CH_W-1:0]              rsp_alpha_ff;

   logic accept, load_ok, front_ok, back_ok, query_err, err_done, alpha_done;

   // ------------------------------------------------------------------
   // Input checks
   // ------------------------------------------------------------------
   always_comb begin
      accept    = start && !busy;
      load_ok   = int'(req_entry_index) < MAX_ENTRIES;
      front_ok  = ({1'b0, req_front_index} < eiu_ff) && (int'(req_front_index) < MAX_ENTRIES);
      back_ok   = ({1'b0, req_back_index} < eiu_ff) && (int'(req_back_index) < MAX_ENTRIES);
      query_err = !(front_ok && back_ok);
      lo_idx    = (req_front_index < req_back_index) ? req_front_index : req_back_index;
      hi_idx    = (req_front_index < req_back_index) ? req_back_index : req_front_index;
      err_done  = accept && (req_kind == KIND_QUERY) && query_err;
      alpha_done = (state_ff == ST_Q_ALPHA) && abit_ff[0];
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            priority if (accept && (req_kind == KIND_LOAD) && load_ok) begin
               state_in = ST_LD_RD;
            end else if (accept && (req_kind == KIND_QUERY) && !query_err) begin
               state_in = ST_Q_RDH;
            end
         end
         ST_LD_RD:    state_in = ST_LD_MUL;
         ST_LD_MUL:   state_in = ST_LD_WR;
         ST_LD_WR:    state_in = ST_IDLE;
         ST_Q_RDH:    state_in = ST_Q_RDL;
         ST_Q_RDL:    state_in = ST_Q_PREP;
         ST_Q_PREP:   state_in = ST_Q_NUM;
         ST_Q_NUM:    state_in = ST_Q_LAUNCH;
         ST_Q_LAUNCH: state_in = ST_Q_DIV;
         ST_Q_DIV: begin
            if (div_busy == '0) begin
               state_in = ST_Q_ALPHA;
            end
         end
         ST_Q_ALPHA: begin
            if (abit_ff[0]) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_LD_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff - AW'(1);
         end
         ST_LD_WR: wr_en = 1'b1;
         ST_Q_RDH: begin
            rd_en   = 1'b1;
            rd_addr = hi_addr_ff;
         end
         ST_Q_RDL: begin
            rd_en   = 1'b1;
            rd_addr = lo_addr_ff;
         end
         ST_Q_LAUNCH: div_start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eiu_ff       <= EIU_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= err_done || alpha_done;
         if (csr_we) begin
            eiu_ff <= csr_wdata;
         end
      end
   end

   // ------------------------------------------------------------------
   // Table storage: one write port, one registered read port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= table_mem[rd_addr];
      end
   end

   // A load extends the integrals of the previous entry; entry zero restarts them.
   always_comb begin
      wr_data.color = color_ff;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         wr_data.color_int[ch] = zero_idx_ff ? '0
                                 : rd_ff.color_int[ch] + INT_W'(prod_ff[ch]);
      end
      wr_data.opacity_int = zero_idx_ff ? '0 : rd_ff.opacity_int + OPA_W'(ta_ff);
   end

   // Three multipliers shared by the load step and the equal-index query.
   always_comb begin
      ta = SUM_W'(rd_ff.color[CH_ALPHA]) + SUM_W'(color_ff[CH_ALPHA]);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (state_ff == ST_Q_PREP) begin
            mop_a[ch] = SUM_W'(hold_ff.color[CH_ALPHA]);
            mop_b[ch] = SUM_W'(hold_ff.color[ch]);
         end else begin
            mop_a[ch] = ta;
            mop_b[ch] = SUM_W'(rd_ff.color[ch]) + SUM_W'(color_ff[ch]);
         end
         prod[ch] = PROD_W'(mop_a[ch]) * PROD_W'(mop_b[ch]);
      end
   end

   // ------------------------------------------------------------------
   // Divider setup and saturation
   // ------------------------------------------------------------------
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         csat[ch]     = cnum_ff[ch] >= (CNUM_W'(cden_ff) << COLOR_QB);
         cdiv_num[ch] = csat[ch] ? '0 : cnum_ff[ch][CDV_W-1:0];
      end
      xsat     = XDV_W'(xnum_ff) >= (XDV_W'(xden_ff) << X_QB);
      xdiv_num = xsat ? '0 : XDV_W'(xnum_ff);
   end

   for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_color_div
      pte_serial_div #(
         .DEN_W (CDEN_W),
         .QB    (COLOR_QB)
      ) u_color_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (cdiv_num[gc]),
         .den   (cden_ff),
         .busy  (div_busy[gc]),
         .quot  (cquot[gc])
      );
   end

   pte_serial_div #(
      .DEN_W (XDEN_W),
      .QB    (X_QB)
   ) u_x_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (xdiv_num),
      .den   (xden_ff),
      .busy  (div_busy[NUM_CH]),
      .quot  (xquot)
   );

   // One opacity level bit per cycle, from the top down.
   always_comb begin
      trial  = acc_ff | abit_ff;
      acc_in = (ALPHA_THR[trial] <= x_ff) ? trial : acc_ff;
   end

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_ff      <= AW'(req_entry_index);
               zero_idx_ff <= req_entry_index == '0;
               color_ff    <= {req_entry_alpha, req_entry_blue, req_entry_green,
                               req_entry_red};
               lo_addr_ff  <= AW'(lo_idx);
               hi_addr_ff  <= AW'(hi_idx);
               n_ff        <= hi_idx - lo_idx;
               eq_ff       <= req_front_index == req_back_index;
            end
         end
         ST_LD_MUL: begin
            prod_ff <= prod;
            ta_ff   <= ta;
         end
         ST_Q_RDL: hold_ff <= rd_ff;
         ST_Q_PREP: begin
            prod_ff <= prod;
            for (int ch = 0; ch < NUM_CH; ch++) begin
               dc_ff[ch] <= (hold_ff.color_int[ch] > rd_ff.color_int[ch])
                            ? hold_ff.color_int[ch] - rd_ff.color_int[ch] : '0;
            end
            da_ff <= (hold_ff.opacity_int > rd_ff.opacity_int)
                     ? hold_ff.opacity_int - rd_ff.opacity_int : '0;
         end
         ST_Q_NUM: begin
            if (eq_ff) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  cnum_ff[ch] <= CNUM_W'(prod_ff[ch]) + CNUM_W'(ROUND_HALF);
               end
               cden_ff <= CDEN_W'(COLOR_FULL);
               xnum_ff <= (XNUM_W'(hold_ff.color[CH_ALPHA]) << FRAC_W)
                          + XNUM_W'(ROUND_HALF);
               xden_ff <= XDEN_W'(COLOR_FULL);
            end else begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  cnum_ff[ch] <= CNUM_W'(dc_ff[ch])
                                 + CNUM_W'(n_ff) * CNUM_W'(COLOR_BIAS_STEP);
               end
               cden_ff <= CDEN_W'(n_ff) * CDEN_W'(COLOR_DEN_STEP);
               xnum_ff <= (XNUM_W'(da_ff) << FRAC_W) + XNUM_W'(n_ff) * XNUM_W'(X_BIAS_STEP);
               xden_ff <= XDEN_W'(n_ff) * XDEN_W'(X_DEN_STEP);
            end
         end
         ST_Q_LAUNCH: begin
            csat_ff <= csat;
            xsat_ff <= xsat;
         end
         ST_Q_DIV: begin
            if (div_busy == '0) begin
               x_ff    <= xsat_ff ? XQ_W'(X_SAT) : XQ_W'(xquot);
               acc_ff  <= '0;
               abit_ff <= ALPHA_MSB;
            end
         end
         ST_Q_ALPHA: begin
            acc_ff  <= acc_in;
            abit_ff <= abit_ff >> 1;
         end
         default: ;
      endcase
   end

   // Result beat payload.
   always_ff @(posedge clock) begin
      if (err_done) begin
         rsp_color_ff <= '0;
         rsp_alpha_ff <= '0;
         rsp_err_ff   <= 1'b1;
      end else if (alpha_done) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            rsp_color_ff[ch] <= csat_ff[ch] ? CH_W'(COLOR_FULL) : cquot[ch];
         end
         rsp_alpha_ff <= acc_in;
         rsp_err_ff   <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = rsp_color_ff[0];
   assign rsp_out_green   = rsp_color_ff[1];
   assign rsp_out_blue    = rsp_color_ff[2];
   assign rsp_out_alpha   = rsp_alpha_ff;
   assign rsp_index_error = rsp_err_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `PTE_ASSERT_NEXT(a_load_silent, clock, reset, accept && (req_kind == KIND_LOAD), !rsp_valid)
   `PTE_ASSERT_NEXT(a_err_next, clock, reset, err_done, rsp_valid && rsp_index_error)
   `PTE_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_index_error, (rsp_out_red == '0) && (rsp_out_green == '0) && (rsp_out_blue == '0) && (rsp_out_alpha == '0))
   `PTE_ASSERT_IMP(a_div_idle, clock, reset, state_ff == ST_IDLE, div_busy == '0)

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the pre-integrated transfer function table engine
// Loads RGBA transfer function entries and queries segments between two
// indices. A shadow copy of the table and its running sums predicts every
// query answer, which is checked field by field against the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import pte_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int X_LIMIT       = 2048;
   localparam int SETTLE_CYCLES = 30;
   localparam int RANDOM_BEATS  = 1300;

   typedef struct packed {
      logic              kind;
      logic [IDX_W-1:0]  entry_index;
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [CH_W-1:0]   alpha;
      logic [IDX_W-1:0]  front;
      logic [IDX_W-1:0]  back;
   } tf_beat_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
      logic            index_error;
   } pixel_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_kind;
   logic [IDX_W-1:0]   req_entry_index;
   logic [CH_W-1:0]    req_entry_red;
   logic [CH_W-1:0]    req_entry_green;
   logic [CH_W-1:0]    req_entry_blue;
   logic [CH_W-1:0]    req_entry_alpha;
   logic [IDX_W-1:0]   req_front_index;
   logic [IDX_W-1:0]   req_back_index;
   logic               rsp_valid;
   logic [CH_W-1:0]    rsp_out_red;
   logic [CH_W-1:0]    rsp_out_green;
   logic [CH_W-1:0]    rsp_out_blue;
   logic [CH_W-1:0]    rsp_out_alpha;
   logic               rsp_index_error;
   logic               csr_we;
   logic [EIU_W-1:0]   csr_wdata;

   // Shadow of the table contents, the running sums and the register.
   logic [CH_W-1:0]    tf_red   [0:TABLE_DEPTH-1];
   logic [CH_W-1:0]    tf_green [0:TABLE_DEPTH-1];
   logic [CH_W-1:0]    tf_blue  [0:TABLE_DEPTH-1];
   logic [CH_W-1:0]    tf_alpha [0:TABLE_DEPTH-1];
   bit   [INT_W-1:0]   red_sum     [0:TABLE_DEPTH-1];
   bit   [INT_W-1:0]   green_sum   [0:TABLE_DEPTH-1];
   bit   [INT_W-1:0]   blue_sum    [0:TABLE_DEPTH-1];
   bit   [OPA_W-1:0]   opacity_sum [0:TABLE_DEPTH-1];
   logic [EIU_W-1:0]   active_entries;
   bit   [CH_W-1:0]    opacity_lut [0:X_LIMIT];

   pixel_type          expected_pixels[$];
   int                 written_count;
   int                 fail_count;
   int                 beats_sent;
   bit                 idle_enable;

   preintegration_table_engine u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_entry_alpha (req_entry_alpha),
      .req_front_index (req_front_index),
      .req_back_index  (req_back_index),
      .rsp_valid       (rsp_valid),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_alpha   (rsp_out_alpha),
      .rsp_index_error (rsp_index_error),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Opacity for every 4.8 optical depth, following the exp(-1/256) chain.
   function automatic void build_opacity_lut();
      bit [63:0] decay;
      decay = 64'h1_0000_0000;
      for (int k = 0; k <= X_LIMIT; k++) begin
         opacity_lut[k] = CH_W'((64'd255 * (64'h1_0000_0000 - decay)
                          + 64'h8000_0000) >> 32);
         decay = (decay * 64'd4278222805 + 64'h8000_0000) >> 32;
      end
   endfunction

   function automatic logic [CH_W-1:0] segment_color(input bit [INT_W-1:0] hi_sum,
                                                     input bit [INT_W-1:0] lo_sum,
                                                     input bit [63:0] span);
      bit [63:0] diff;
      bit [63:0] avg;
      diff = (hi_sum > lo_sum) ? 64'(hi_sum) - 64'(lo_sum) : 64'd0;
      avg  = (diff + span * 510) / (span * 1020);
      return (avg > 255) ? CH_W'(255) : avg[CH_W-1:0];
   endfunction

   function automatic pixel_type preintegrate_segment(input logic [IDX_W-1:0] front,
                                                      input logic [IDX_W-1:0] back);
      pixel_type  px;
      int         limit;
      int         lo;
      int         hi;
      bit [63:0]  span;
      bit [63:0]  depth_diff;
      bit [63:0]  xq;
      bit [31:0]  a;
      px    = '0;
      limit = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries);
      if (front >= limit || back >= limit) begin
         px.index_error = 1'b1;
         return px;
      end
      lo = (front < back) ? front : back;
      hi = (front < back) ? back : front;
      if (lo == hi) begin
         a        = tf_alpha[lo];
         px.red   = CH_W'((tf_red[lo] * a + 127) / 255);
         px.green = CH_W'((tf_green[lo] * a + 127) / 255);
         px.blue  = CH_W'((tf_blue[lo] * a + 127) / 255);
         px.alpha = opacity_lut[(a * 256 + 127) / 255];
      end else begin
         span       = hi - lo;
         px.red     = segment_color(red_sum[hi], red_sum[lo], span);
         px.green   = segment_color(green_sum[hi], green_sum[lo], span);
         px.blue    = segment_color(blue_sum[hi], blue_sum[lo], span);
         depth_diff = (opacity_sum[hi] > opacity_sum[lo])
                      ? 64'(opacity_sum[hi]) - 64'(opacity_sum[lo]) : 64'd0;
         xq         = (depth_diff * 256 + span * 255) / (span * 510);
         if (xq > X_LIMIT) xq = X_LIMIT;
         px.alpha   = opacity_lut[xq];
      end
      return px;
   endfunction

   // A load extends the sums from the stored entry below it, whatever order
   // the loads come in.
   function automatic void apply_load(input tf_beat_type beat);
      int        i;
      bit [63:0] ta;
      i = beat.entry_index;
      if (i == 0) begin
         red_sum[0]     = '0;
         green_sum[0]   = '0;
         blue_sum[0]    = '0;
         opacity_sum[0] = '0;
      end else begin
         ta             = 64'(tf_alpha[i-1]) + 64'(beat.alpha);
         red_sum[i]     = INT_W'(red_sum[i-1] + ta * (64'(tf_red[i-1]) + beat.red));
         green_sum[i]   = INT_W'(green_sum[i-1] + ta * (64'(tf_green[i-1]) + beat.green));
         blue_sum[i]    = INT_W'(blue_sum[i-1] + ta * (64'(tf_blue[i-1]) + beat.blue));
         opacity_sum[i] = OPA_W'(opacity_sum[i-1] + ta);
      end
      tf_red[i]   = beat.red;
      tf_green[i] = beat.green;
      tf_blue[i]  = beat.blue;
      tf_alpha[i] = beat.alpha;
      if (i + 1 > written_count) written_count = i + 1;
   endfunction

   function automatic tf_beat_type random_beat();
      tf_beat_type beat;
      beat.kind        = KIND_LOAD;
      beat.entry_index = IDX_W'($urandom_range(0, 255));
      beat.red         = CH_W'($urandom_range(0, 255));
      beat.green       = CH_W'($urandom_range(0, 255));
      beat.blue        = CH_W'($urandom_range(0, 255));
      beat.alpha       = CH_W'($urandom_range(0, 255));
      beat.front       = IDX_W'($urandom_range(0, 255));
      beat.back        = IDX_W'($urandom_range(0, 255));
      return beat;
   endfunction

   // Mostly random, with the two extremes favored.
   function automatic logic [CH_W-1:0] pick_level();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return CH_W'($urandom_range(0, 255));
   endfunction

   task automatic send_beat(input tf_beat_type beat);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 30);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_kind        <= beat.kind;
      req_entry_index <= beat.entry_index;
      req_entry_red   <= beat.red;
      req_entry_green <= beat.green;
      req_entry_blue  <= beat.blue;
      req_entry_alpha <= beat.alpha;
      req_front_index <= beat.front;
      req_back_index  <= beat.back;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (beat.kind == KIND_LOAD) begin
         apply_load(beat);
      end else begin
         expected_pixels.push_back(preintegrate_segment(beat.front, beat.back));
      end
      beats_sent++;
   endtask

   task automatic load_entry(input int idx, input int r, input int g, input int b,
                             input int a);
      tf_beat_type beat;
      beat             = random_beat();
      beat.kind        = KIND_LOAD;
      beat.entry_index = IDX_W'(idx);
      beat.red         = CH_W'(r);
      beat.green       = CH_W'(g);
      beat.blue        = CH_W'(b);
      beat.alpha       = CH_W'(a);
      send_beat(beat);
   endtask

   task automatic query_pair(input int front, input int back);
      tf_beat_type beat;
      beat       = random_beat();
      beat.kind  = KIND_QUERY;
      beat.front = IDX_W'(front);
      beat.back  = IDX_W'(back);
      send_beat(beat);
   endtask

   // The register is only touched once the engine has gone quiet.
   task automatic write_entries_in_use(input int value);
      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= EIU_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      active_entries = EIU_W'(value);
   endtask

   task automatic report_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : result_check
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha, rsp_index_error};
         if (expected_pixels.size() == 0) begin
            report_fail($sformatf("Unexpected result beat at %0t: rgba %0d %0d %0d %0d err %0b",
                                  $realtime, got.red, got.green, got.blue, got.alpha,
                                  got.index_error));
         end else begin
            want = expected_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
                || got.alpha !== want.alpha || got.index_error !== want.index_error) begin
               report_fail($sformatf(
                  "Mismatch at %0t: expected rgba %0d %0d %0d %0d err %0b, got %0d %0d %0d %0d err %0b",
                  $realtime, want.red, want.green, want.blue, want.alpha, want.index_error,
                  got.red, got.green, got.blue, got.alpha, got.index_error));
            end
         end
      end
   end

   task automatic test_basic_segments();
      write_entries_in_use(256);
      load_entry(0, 255, 255, 255, 255);
      load_entry(1, 0, 0, 0, 0);
      load_entry(2, 255, 0, 128, 255);
      load_entry(3, 1, 2, 4, 8);
      query_pair(0, 0);
      query_pair(2, 2);
      query_pair(1, 1);
      query_pair(0, 3);
      query_pair(3, 0);
      query_pair(1, 2);
   endtask

   task automatic test_index_limit();
      write_entries_in_use(2);
      query_pair(0, 1);
      query_pair(1, 1);
      query_pair(2, 0);
      query_pair(0, 2);
      query_pair(255, 255);
      query_pair(1, 255);
   endtask

   // Reloading entry 1 leaves the sums above it stale, so the color
   // difference up to entry 2 turns negative and must read as zero.
   task automatic test_stale_sums();
      write_entries_in_use(256);
      load_entry(1, 255, 255, 255, 255);
      query_pair(1, 2);
      query_pair(2, 1);
      query_pair(0, 2);
   endtask

   task automatic random_query();
      int limit;
      int top;
      int sel;
      int lo;
      int hi;
      limit = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries);
      top   = (written_count < limit) ? written_count : limit;
      sel   = $urandom_range(0, 99);
      if (sel < 12 && limit < TABLE_DEPTH) begin
         if ($urandom_range(0, 1)) query_pair($urandom_range(limit, 255), $urandom_range(0, 255));
         else query_pair($urandom_range(0, 255), $urandom_range(limit, 255));
      end else if (sel < 24) begin
         lo = $urandom_range(0, top - 1);
         query_pair(lo, lo);
      end else begin
         // Short segments catch the stale sums left behind by reloads.
         lo = $urandom_range(0, top - 2);
         if (sel < 50) begin
            hi = lo + $urandom_range(1, 3);
            if (hi > top - 1) hi = top - 1;
         end else begin
            hi = $urandom_range(lo + 1, top - 1);
         end
         if ($urandom_range(0, 1)) query_pair(lo, hi);
         else query_pair(hi, lo);
      end
   endtask

   task automatic test_random_traffic();
      int round;
      int len;
      int mode;
      int first_beat;
      int idx;
      round      = 0;
      first_beat = beats_sent;
      while (beats_sent - first_beat < RANDOM_BEATS) begin
         case (round % 5)
            0:       write_entries_in_use(256);
            1:       write_entries_in_use(2);
            default: write_entries_in_use($urandom_range(2, 256));
         endcase
         idle_enable = (round % 4 != 3);
         // Rebuild a prefix of the table; a uniform opacity in the prefix
         // makes sharp jumps against the old sums above it.
         len  = (round % 7 == 0) ? TABLE_DEPTH : $urandom_range(2, 48);
         mode = $urandom_range(0, 2);
         for (int k = 0; k < len; k++) begin
            load_entry(k, pick_level(), pick_level(), pick_level(),
                       (mode == 0) ? 255 : (mode == 1) ? 0 : pick_level());
         end
         for (int k = 0; k < 90; k++) begin
            if ($urandom_range(0, 99) < 65) begin
               random_query();
            end else begin
               idx = $urandom_range(0, (written_count < TABLE_DEPTH) ? written_count
                                                                     : TABLE_DEPTH - 1);
               load_entry(idx, pick_level(), pick_level(), pick_level(), pick_level());
            end
         end
         round++;
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_kind        = KIND_LOAD;
      req_entry_index = '0;
      req_entry_red   = '0;
      req_entry_green = '0;
      req_entry_blue  = '0;
      req_entry_alpha = '0;
      req_front_index = '0;
      req_back_index  = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      active_entries  = EIU_RESET;
      written_count   = 0;
      fail_count      = 0;
      beats_sent      = 0;
      idle_enable     = 1'b1;
      build_opacity_lut();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_segments();
      test_index_limit();
      test_stale_sums();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/pte_pkg.sv
rtl/pte_serial_div.sv
rtl/preintegration_table_engine.sv
verif/tb_top.sv
